@@ hw/rtl/tfss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfss_pkg
// shared types and constants of the tape feeder step sequencer
// ----------------------------------------------------------------------------
package tfss_pkg;

  localparam int CFG_W      = 8;
  localparam int BOUNCE_W   = CFG_W + 1;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WAIT_TICKS = 2'd1;

  // reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_LIMIT_RST  = 8'd10;
  localparam logic [CFG_W-1:0] STEP_WAIT_TICKS_RST = 8'd10;

  // two-sample hole history patterns
  localparam logic [1:0] HIST_BOTH_HOLE = 2'b11;
  localparam logic [1:0] HIST_NO_HOLE   = 2'b00;

  typedef enum logic [2:0] {
    PH_GAP    = 3'd0,
    PH_IDLE   = 3'd1,
    PH_CLEAR  = 3'd2,
    PH_SEEK   = 3'd3,
    PH_REWIND = 3'd4
  } phase_t;

  typedef struct packed {
    logic button_pressed;
    logic feed_level;
    logic hole_seen;
    logic tension_ok;
  } tick_t;

  typedef struct packed {
    phase_t           phase;
    logic [1:0]       hist;
    logic [CFG_W-1:0] wait_cnt;
    logic             gear_dir;
  } seq_state_t;

  typedef struct packed {
    logic gear_pulse;
    logic rewind_pulse;
  } seq_pulse_t;

endpackage
`default_nettype wire

@@ hw/rtl/tfss_req.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfss_req
// feed request latching: feed line falling edge and button debounce
// ----------------------------------------------------------------------------
module tfss_req (
  input  tfss_pkg::tick_t                  tick,
  input  logic                             feed_prev,
  input  logic                             pending,
  input  logic [tfss_pkg::BOUNCE_W-1:0]    bounce,
  input  logic [tfss_pkg::CFG_W-1:0]       debounce_limit,
  output logic                             pending_nxt,
  output logic [tfss_pkg::BOUNCE_W-1:0]    bounce_nxt
);
  import tfss_pkg::*;

  logic [BOUNCE_W-1:0] limit_ext;

  assign limit_ext = {1'b0, debounce_limit};

  always_comb begin
    pending_nxt = pending | (feed_prev & ~tick.feed_level);
    bounce_nxt  = bounce;
    if (tick.button_pressed) begin
      if (bounce == limit_ext) begin
        bounce_nxt  = bounce + BOUNCE_W'(1);
        pending_nxt = 1'b1;
      end else if (bounce < limit_ext) begin
        bounce_nxt = bounce + BOUNCE_W'(1);
      end
    end else begin
      bounce_nxt = '0;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tfss_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tfss_seq
// step wait countdown and phase sequencing for one tick
// ----------------------------------------------------------------------------
module tfss_seq (
  input  tfss_pkg::seq_state_t         cur,
  input  logic                         pending,
  input  logic                         hole_seen,
  input  logic                         tension_ok,
  input  logic [tfss_pkg::CFG_W-1:0]   step_wait_ticks,
  output tfss_pkg::seq_state_t         nxt,
  output logic                         pending_nxt,
  output tfss_pkg::seq_pulse_t         pulse
);
  import tfss_pkg::*;

  seq_state_t s;
  logic       act;
  logic       run;
  logic       pend;
  logic       gp;
  logic       rp;

  always_comb begin
    s    = cur;
    pend = pending;
    gp   = 1'b0;
    rp   = 1'b0;
    act  = 1'b1;
    run  = 1'b0;

    // countdown, act on the tick it reaches zero
    if (cur.wait_cnt != '0) begin
      s.wait_cnt = cur.wait_cnt - CFG_W'(1);
      act        = (s.wait_cnt == '0);
    end

    if (act) begin
      case (s.phase)
        PH_IDLE, PH_CLEAR, PH_SEEK, PH_REWIND: run = 1'b1;
        default:                               s.phase = PH_IDLE;
      endcase
    end

    if (run) begin
      if (s.phase == PH_IDLE && pend) begin
        pend    = 1'b0;
        s.phase = PH_CLEAR;
      end
      if (s.phase == PH_CLEAR) begin
        s.hist = {s.hist[0], hole_seen};
        if (s.hist == HIST_NO_HOLE) s.phase = PH_SEEK;
        else                        gp      = 1'b1;
      end
      // same sample shifts in again when clear finishes this tick
      if (s.phase == PH_SEEK && !gp) begin
        s.hist = {s.hist[0], hole_seen};
        if (s.hist == HIST_BOTH_HOLE) s.phase = PH_REWIND;
        else                          gp      = 1'b1;
      end
      if (s.phase == PH_REWIND) begin
        if (tension_ok) s.phase = PH_GAP;
        else            rp      = 1'b1;
      end
      if (gp) begin
        s.gear_dir = 1'b1;
        s.wait_cnt = step_wait_ticks;
      end else if (rp) begin
        s.gear_dir = 1'b0;
        s.wait_cnt = step_wait_ticks;
      end
    end

    nxt                = s;
    pending_nxt        = pend;
    pulse.gear_pulse   = gp;
    pulse.rewind_pulse = rp;
  end

endmodule
`default_nettype wire

@@ hw/rtl/tape_feeder_step_sequencer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tape_feeder_step_sequencer_core
// tick-driven feed sequencer for a tape feeder gear and rewinder stepper
// ----------------------------------------------------------------------------
// usage:
//   - in_* channel: one transaction per 1 ms tick carrying the sampled button,
//     feed line, tape hole and tension levels (valid/stall handshake)
//   - out_* channel: one transaction per tick with the gear and rewinder step
//     pulses, the direction levels and the phase after that tick
//   - cfg_* channel: register writes (debounce limit, step wait), always ready;
//     write only while no tick transaction is in flight
//   - path: a tick waits in the input register, then out_* shows the result register
//   - throughput: one tick per clock while out_stall is low, set by the input
//     register feeding one stage of next-state logic into the result register
//   - reset: phase restart gap, feed line taken as idle high, counters and
//     hole history cleared, both registers back to 10
//   - receiver stall: the result register holds; the input register takes one
//     more tick, then in_stall rises until the result moves on
// ----------------------------------------------------------------------------
module tape_feeder_step_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_button_pressed,
  input  logic                               in_feed_level,
  input  logic                               in_hole_seen,
  input  logic                               in_tension_ok,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_gear_pulse,
  output logic                               out_gear_forward,
  output logic                               out_rewind_pulse,
  output logic                               out_rewind_dir_level,
  output logic [2:0]                         out_phase,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfss_pkg::CFG_W-1:0]         cfg_data
);
  import tfss_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]    debounce_limit_r;
  logic [CFG_W-1:0]    step_wait_ticks_r;

  // input register
  logic                in_vld_r;
  tick_t               in_item_r;

  // sequencer state
  seq_state_t          seq_r;
  seq_state_t          seq_nxt;
  logic [BOUNCE_W-1:0] bounce_r;
  logic [BOUNCE_W-1:0] bounce_nxt;
  logic                pending_r;
  logic                pending_nxt;
  logic                feed_prev_r;

  // result register
  logic                out_vld_r;
  seq_pulse_t          pulse_r;
  seq_pulse_t          pulse_nxt;
  logic                gear_fwd_r;
  phase_t              phase_out_r;

  logic                req_pending;
  logic                adv;
  logic                in_take;

  // tick moves into the result register when that register is free or leaving
  assign adv       = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall  = in_vld_r & ~adv;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  tfss_req u_req (
    .tick           (in_item_r),
    .feed_prev      (feed_prev_r),
    .pending        (pending_r),
    .bounce         (bounce_r),
    .debounce_limit (debounce_limit_r),
    .pending_nxt    (req_pending),
    .bounce_nxt     (bounce_nxt)
  );

  // request latched on this tick may start the cycle on the same tick
  tfss_seq u_seq (
    .cur             (seq_r),
    .pending         (req_pending),
    .hole_seen       (in_item_r.hole_seen),
    .tension_ok      (in_item_r.tension_ok),
    .step_wait_ticks (step_wait_ticks_r),
    .nxt             (seq_nxt),
    .pending_nxt     (pending_nxt),
    .pulse           (pulse_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_limit_r  <= DEBOUNCE_LIMIT_RST;
      step_wait_ticks_r <= STEP_WAIT_TICKS_RST;
      in_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      seq_r.phase       <= PH_GAP;
      seq_r.hist        <= HIST_NO_HOLE;
      seq_r.wait_cnt    <= '0;
      seq_r.gear_dir    <= 1'b0;
      bounce_r          <= '0;
      pending_r         <= 1'b0;
      feed_prev_r       <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE_LIMIT:  debounce_limit_r  <= cfg_data;
          CFG_STEP_WAIT_TICKS: step_wait_ticks_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_take)  in_vld_r <= 1'b1;
      else if (adv) in_vld_r <= 1'b0;
      out_vld_r <= adv | (out_vld_r & out_stall);
      if (adv) begin
        seq_r       <= seq_nxt;
        bounce_r    <= bounce_nxt;
        pending_r   <= pending_nxt;
        feed_prev_r <= in_item_r.feed_level;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.button_pressed <= in_button_pressed;
      in_item_r.feed_level     <= in_feed_level;
      in_item_r.hole_seen      <= in_hole_seen;
      in_item_r.tension_ok     <= in_tension_ok;
    end
    if (adv) begin
      pulse_r     <= pulse_nxt;
      gear_fwd_r  <= seq_nxt.gear_dir;
      phase_out_r <= seq_nxt.phase;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_gear_pulse       = pulse_r.gear_pulse;
  assign out_gear_forward     = gear_fwd_r;
  assign out_rewind_pulse     = pulse_r.rewind_pulse;
  assign out_rewind_dir_level = 1'b0;
  assign out_phase            = phase_out_r;

  // only one stepper moves per tick
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(pulse_r.gear_pulse && pulse_r.rewind_pulse))
    else $error("gear and rewind pulse on the same tick");

  // a gear step leaves the gear direction forward
  a_gear_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && pulse_r.gear_pulse) |-> gear_fwd_r)
    else $error("gear pulse without forward direction");

  // a running step wait only exists inside an active feed cycle
  a_wait_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.wait_cnt != '0) |->
      (seq_r.phase == PH_CLEAR || seq_r.phase == PH_SEEK || seq_r.phase == PH_REWIND))
    else $error("step wait running outside a feed cycle");

  // a tick taken while the result register is free shows up on the next edge
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |=> out_vld_r)
    else $error("tick did not reach the result register");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tape feeder step sequencer: a tick table and
// shaped random feed cycles run under several register settings, with every
// result checked against a typed row result or a tick-level model kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
  import tfss_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 25;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    logic   gear_pulse;
    logic   gear_forward;
    logic   rewind_pulse;
    logic   rewind_dir_level;
    phase_t phase;
  } step_out_t;

  typedef struct packed {
    tick_t     tick;
    logic      typed;
    step_out_t want;
  } stim_row_t;

  localparam step_out_t NO_RES = '0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid          = 1'b0;
  logic       in_stall;
  logic       in_button_pressed = 1'b0;
  logic       in_feed_level     = 1'b1;
  logic       in_hole_seen      = 1'b0;
  logic       in_tension_ok     = 1'b0;
  logic       out_valid;
  logic       out_stall         = 1'b0;
  logic       out_gear_pulse;
  logic       out_gear_forward;
  logic       out_rewind_pulse;
  logic       out_rewind_dir_level;
  logic [2:0] out_phase;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE_LIMIT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // idle percentages of the two sides
  int in_idle_pct  = 28;
  int out_idle_pct = 73;
  int fail_cnt     = 0;
  int cycle_cnt    = 0;

  // model of the sequencer: registers and state, at reset values
  logic [CFG_W-1:0]    dl_cfg     = DEBOUNCE_LIMIT_RST;
  logic [CFG_W-1:0]    sw_cfg     = STEP_WAIT_TICKS_RST;
  phase_t              seq_ph     = PH_GAP;
  logic [CFG_W-1:0]    wait_left  = '0;
  logic [1:0]          hole_hist  = '0;
  logic [BOUNCE_W-1:0] held_ticks = '0;
  logic                fd_pending = 1'b0;
  logic                fd_prev    = 1'b1;
  logic                gear_fwd   = 1'b0;

  // outputs still owed by the block, oldest first
  step_out_t pending_step_outputs [$];

  // shaping state of the random tick source
  logic gen_hole      = 1'b0;
  int   hold_left     = 0;
  int   feed_low_left = 0;

  stim_row_t dir_rows [DIR_N];

  tape_feeder_step_sequencer_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_button_pressed   (in_button_pressed),
    .in_feed_level       (in_feed_level),
    .in_hole_seen        (in_hole_seen),
    .in_tension_ok       (in_tension_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gear_pulse      (out_gear_pulse),
    .out_gear_forward    (out_gear_forward),
    .out_rewind_pulse    (out_rewind_pulse),
    .out_rewind_dir_level(out_rewind_dir_level),
    .out_phase           (out_phase),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // one tick of the sequencer: request latching, wait countdown, phase chain
  function automatic step_out_t advance_sequencer(input tick_t t);
    step_out_t r;
    logic      act;
    r   = NO_RES;
    act = 1'b1;
    // falling feed line or a button held past the debounce limit
    if (fd_prev && !t.feed_level) fd_pending = 1'b1;
    fd_prev = t.feed_level;
    if (t.button_pressed) begin
      if (held_ticks == {1'b0, dl_cfg}) begin
        held_ticks++;
        fd_pending = 1'b1;
      end else if (held_ticks < {1'b0, dl_cfg}) begin
        held_ticks++;
      end
    end else begin
      held_ticks = '0;
    end
    // the phase acts only once the wait has run out
    if (wait_left != '0) begin
      wait_left--;
      if (wait_left != '0) act = 1'b0;
    end
    if (act) begin
      if (seq_ph == PH_GAP || seq_ph > PH_REWIND) begin
        seq_ph = PH_IDLE;
      end else begin
        if (seq_ph == PH_IDLE && fd_pending) begin
          fd_pending = 1'b0;
          seq_ph     = PH_CLEAR;
        end
        if (seq_ph == PH_CLEAR) begin
          hole_hist = {hole_hist[0], t.hole_seen};
          if (hole_hist == HIST_NO_HOLE) seq_ph = PH_SEEK;
          else r.gear_pulse = 1'b1;
        end
        // seek takes the same sample again when clear just finished
        if (seq_ph == PH_SEEK && !r.gear_pulse) begin
          hole_hist = {hole_hist[0], t.hole_seen};
          if (hole_hist == HIST_BOTH_HOLE) seq_ph = PH_REWIND;
          else r.gear_pulse = 1'b1;
        end
        if (seq_ph == PH_REWIND) begin
          if (t.tension_ok) seq_ph = PH_GAP;
          else r.rewind_pulse = 1'b1;
        end
        if (r.gear_pulse) begin
          gear_fwd  = 1'b1;
          wait_left = sw_cfg;
        end else if (r.rewind_pulse) begin
          gear_fwd  = 1'b0;
          wait_left = sw_cfg;
        end
      end
    end
    r.gear_forward     = gear_fwd;
    r.rewind_dir_level = 1'b0;
    r.phase            = seq_ph;
    return r;
  endfunction

  // mostly plausible feeder activity: slow hole changes, short feed pulses,
  // button holds short or around the debounce limit, plus some pure noise
  function automatic tick_t feeder_activity();
    tick_t t;
    if ($urandom_range(9) == 0) begin
      t = tick_t'(4'($urandom_range(15)));
      return t;
    end
    if ($urandom_range(3) == 0) gen_hole = ~gen_hole;
    if (hold_left > 0) hold_left--;
    else if ($urandom_range(29) == 0)
      hold_left = $urandom_range(1) ? $urandom_range(4, 1) : $urandom_range(int'(dl_cfg) + 3, 1);
    if (feed_low_left > 0) feed_low_left--;
    else if ($urandom_range(24) == 0) feed_low_left = $urandom_range(3, 1);
    t.button_pressed = (hold_left > 0);
    t.feed_level     = (feed_low_left == 0);
    t.hole_seen      = gen_hole;
    t.tension_ok     = ($urandom_range(3) == 0);
    return t;
  endfunction

  // drive one tick transaction; returns at the edge that accepts it
  task automatic send_tick(input tick_t t, input logic typed, input step_out_t want);
    logic      stall_seen;
    step_out_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_button_pressed <= t.button_pressed;
    in_feed_level     <= t.feed_level;
    in_hole_seen      <= t.hole_seen;
    in_tension_ok     <= t.tension_ok;
    do begin
      @(negedge clk);
      stall_seen = in_stall;
      @(posedge clk);
    end while (stall_seen);
    r = advance_sequencer(t);
    pending_step_outputs.push_back(typed ? want : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    case (idx)
      CFG_DEBOUNCE_LIMIT:  dl_cfg = val;
      CFG_STEP_WAIT_TICKS: sw_cfg = val;
      default: ;
    endcase
  endtask

  // receiver stall pattern, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // outputs are stable at the falling edge; a result seen here with no stall
  // is taken by the next rising edge
  always @(negedge clk) begin : check_results
    step_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_step_outputs.size() == 0) begin
        $error("result transaction with no tick outstanding");
        fail_cnt++;
      end else begin
        want = pending_step_outputs.pop_front();
        if (out_gear_pulse !== want.gear_pulse) begin
          $error("gear_pulse: expected %0d, got %0d", want.gear_pulse, out_gear_pulse);
          fail_cnt++;
        end
        if (out_gear_forward !== want.gear_forward) begin
          $error("gear_forward: expected %0d, got %0d", want.gear_forward, out_gear_forward);
          fail_cnt++;
        end
        if (out_rewind_pulse !== want.rewind_pulse) begin
          $error("rewind_pulse: expected %0d, got %0d", want.rewind_pulse, out_rewind_pulse);
          fail_cnt++;
        end
        if (out_rewind_dir_level !== want.rewind_dir_level) begin
          $error("rewind_dir_level: expected %0d, got %0d",
                 want.rewind_dir_level, out_rewind_dir_level);
          fail_cnt++;
        end
        if (out_phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, out_phase);
          fail_cnt++;
        end
      end
    end
  end

  // hard stop if the handshakes ever hang
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tape_feeder_step_sequencer_core: mismatch");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] dl;
    logic [CFG_W-1:0] sw;
    int               n_items;

    // button, feed line, hole, tension; typed rows carry an obvious result
    dir_rows = '{
      '{4'b0110, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, PH_IDLE}},   // gap moves to idle
      '{4'b0010, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, PH_CLEAR}},  // feed fall starts at once
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},     // button held through the wait
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},
      '{4'b1100, 1'b0, NO_RES},                               // debounce limit reached
      '{4'b1100, 1'b0, NO_RES}, '{4'b1100, 1'b0, NO_RES},     // held on: no new request
      '{4'b0110, 1'b0, NO_RES}, '{4'b0101, 1'b0, NO_RES},
      '{4'b0111, 1'b0, NO_RES}, '{4'b0110, 1'b0, NO_RES},
      '{4'b0001, 1'b0, NO_RES}, '{4'b0111, 1'b0, NO_RES},
      '{4'b0110, 1'b0, NO_RES}, '{4'b0101, 1'b0, NO_RES},
      '{4'b1111, 1'b0, NO_RES}, '{4'b0000, 1'b0, NO_RES}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table under the reset register values, sender idles more lightly
    for (int i = 0; i < DIR_N; i++) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // registers change only with nothing in flight
      while (pending_step_outputs.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
      case (p)
        0: begin dl = 8'd0;   sw = 8'd1;   end
        1: begin dl = 8'd255; sw = 8'd0;   end   // zero wait steps every tick
        2: begin dl = 8'd4;   sw = 8'd3;   end
        3: begin dl = 8'($urandom_range(255)); sw = 8'd255; end
        default: begin
          dl = 8'($urandom_range(20));
          sw = 8'($urandom_range(8, 1));
        end
      endcase
      write_reg(CFG_DEBOUNCE_LIMIT, dl);
      write_reg(CFG_STEP_WAIT_TICKS, sw);
      cfg_valid <= 1'b0;
      // light sender gaps first, then heavy, then none; receiver heavy, light, none
      in_idle_pct  = (p < 2) ? 28 : (p < 4) ? 73 : 0;
      out_idle_pct = (p < 2) ? 73 : (p < 4) ? 28 : 0;
      n_items      = (p == 3) ? 75 : 150;
      for (int i = 0; i < n_items; i++) send_tick(feeder_activity(), 1'b0, NO_RES);
      in_valid <= 1'b0;
    end

    while (pending_step_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tape_feeder_step_sequencer_core: match");
    end else begin
      $display("tape_feeder_step_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
